>>> hw/rtl/pflt_pkg.sv
// ----------------------------------------------------------------------------
// pflt_pkg: shared types, codes and crc helpers
// Item, result, state and register types of the protected frame link, plus
// the 8-bit check byte taken from a crc-32 over a reordered payload.
// ----------------------------------------------------------------------------
package pflt_pkg;

  // register map, word index taken from paddr[3:2]
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] REG_CONTROL_ID = 2'd0;
  localparam logic [1:0] REG_POWER_ID   = 2'd1;
  localparam logic [1:0] REG_HEATER_ID  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT    = 2'd3;

  localparam logic [10:0] CONTROL_ID_RST = 11'h43A;
  localparam logic [10:0] POWER_ID_RST   = 11'h438;
  localparam logic [10:0] HEATER_ID_RST  = 11'h439;
  localparam logic [7:0]  TIMEOUT_RST    = 8'd5;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int unsigned InTdataW  = 168;
  localparam int unsigned OutTdataW = 80;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    RX_OK        = 2'd0,
    RX_IGNORED   = 2'd1,
    RX_BAD_CRC   = 2'd2,
    RX_BAD_COUNT = 2'd3
  } rx_status_t;

  typedef struct packed {
    logic               kind;
    logic [10:0]        frame_id;
    logic [3:0]         frame_length;
    logic [63:0]        frame_payload;
    logic [4:0]         heater_flags;
    logic signed [15:0] hv_voltage;
    logic signed [15:0] hv_current;
    logic signed [15:0] loss_power;
    logic signed [31:0] max_power;
  } pflt_item_t;

  typedef struct packed {
    logic        is_transmit;
    logic [10:0] out_id;
    logic [63:0] out_payload;
    rx_status_t  rx_status;
    logic        close_request;
    logic        last;
  } pflt_result_t;

  typedef struct packed {
    logic       counter_seen;
    logic [3:0] last_rx_count;
    logic       request_latch;
    logic [7:0] timeout_left;
    logic [3:0] tx_count;
  } pflt_state_t;

  typedef struct packed {
    logic [10:0] control_frame_id;
    logic [10:0] power_status_id;
    logic [10:0] heater_status_id;
    logic [7:0]  timeout_reload;
  } pflt_cfg_t;

  // bit-serial crc, only evaluated on constants at elaboration
  function automatic logic [31:0] crc_raw(input logic [63:0] stream,
                                          input logic [31:0] init);
    logic [31:0] crc;
    logic        fb;
    crc = init;
    for (int i = 0; i < 64; i++) begin
      fb  = crc[31] ^ stream[63-i];
      crc = {crc[30:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  // per output bit, the stream bits that feed it
  function automatic logic [7:0][63:0] crc_masks();
    logic [7:0][63:0] m;
    logic [31:0]      r;
    m = '0;
    for (int i = 0; i < 64; i++) begin
      r = crc_raw(64'd1 << i, 32'd0);
      for (int j = 0; j < 8; j++) begin
        m[j][i] = r[j];
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] crc_init_term();
    logic [31:0] r;
    r = crc_raw(64'd0, CRC_INIT);
    return r[7:0];
  endfunction

  localparam logic [7:0][63:0] CRC_MASK  = crc_masks();
  localparam logic [7:0]       CRC_CONST = crc_init_term();

  // check byte over bytes 3,2,1,0, a zero byte, then 6,5,4
  function automatic logic [7:0] frame_crc8(input logic [63:0] p);
    logic [63:0] stream;
    logic [7:0]  c;
    stream = {p[31:0], 8'h00, p[55:32]};
    for (int j = 0; j < 8; j++) begin
      c[j] = CRC_CONST[j] ^ (^(stream & CRC_MASK[j]));
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/pflt_eval.sv
// ----------------------------------------------------------------------------
// pflt_eval: per-item evaluation
// Checks a received control frame or builds the two tick frames, and gives
// the state after the item.
// ----------------------------------------------------------------------------
module pflt_eval
  import pflt_pkg::*;
(
  input  pflt_item_t   item,
  input  pflt_state_t  state,
  input  pflt_cfg_t    cfg,
  output pflt_result_t res_first,
  output pflt_result_t res_second,
  output logic         two_results,
  output pflt_state_t  state_nxt
);

  logic               id_ok;
  logic               crc_ok;
  logic [3:0]         rx_cnt;
  logic               cnt_ok;
  rx_status_t         rx_st;
  logic signed [31:0] prod;
  logic [31:0]        prod_c;
  logic [31:0]        loss_c;
  logic [31:0]        max_c;
  logic [31:0]        power_sum;
  logic [7:0]         timeout_dec;
  logic               req_tick;
  logic [63:0]        hs_base;
  logic [63:0]        hs_payload;

  assign id_ok  = (item.frame_id == cfg.control_frame_id) && item.frame_length[3];
  assign crc_ok = frame_crc8(item.frame_payload) == item.frame_payload[63:56];
  assign rx_cnt = item.frame_payload[51:48];
  assign cnt_ok = !state.counter_seen || (rx_cnt == state.last_rx_count + 4'd1);

  always_comb begin
    priority if (!id_ok) begin
      rx_st = RX_IGNORED;
    end else if (!crc_ok) begin
      rx_st = RX_BAD_CRC;
    end else if (!cnt_ok) begin
      rx_st = RX_BAD_COUNT;
    end else begin
      rx_st = RX_OK;
    end
  end

  // charge power frame
  assign prod      = $signed(32'(item.hv_voltage)) * $signed(32'(item.hv_current));
  assign prod_c    = prod[31] ? 32'd0 : 32'(prod);
  assign loss_c    = item.loss_power[15] ? 32'd0 : {16'd0, item.loss_power};
  assign max_c     = item.max_power[31] ? 32'd0 : item.max_power;
  assign power_sum = prod_c + loss_c;

  // timeout counts down before the heater frame is built
  assign timeout_dec = (state.timeout_left != 8'd0) ? state.timeout_left - 8'd1
                                                    : state.timeout_left;
  assign req_tick    = (timeout_dec == 8'd0) ? 1'b0 : state.request_latch;

  assign hs_base = {8'h00, 4'h0, state.tx_count, 7'd0, req_tick,
                    7'd0, item.heater_flags[4], 7'd0, item.heater_flags[3],
                    7'd0, item.heater_flags[2], 7'd0, item.heater_flags[1],
                    7'd0, item.heater_flags[0]};
  assign hs_payload = {frame_crc8(hs_base), hs_base[55:0]};

  always_comb begin
    state_nxt   = state;
    two_results = 1'b0;
    res_first   = '0;
    res_second  = '0;
    if (item.kind == KIND_TICK) begin
      two_results            = 1'b1;
      state_nxt.timeout_left = timeout_dec;
      state_nxt.request_latch = req_tick;
      state_nxt.tx_count     = state.tx_count + 4'd1;

      res_first.is_transmit   = 1'b1;
      res_first.out_id        = cfg.power_status_id;
      res_first.out_payload   = {max_c, power_sum};
      res_first.rx_status     = RX_OK;
      res_first.close_request = req_tick;
      res_first.last          = 1'b0;

      res_second.is_transmit   = 1'b1;
      res_second.out_id        = cfg.heater_status_id;
      res_second.out_payload   = hs_payload;
      res_second.rx_status     = RX_OK;
      res_second.close_request = req_tick;
      res_second.last          = 1'b1;
    end else begin
      if (rx_st == RX_OK) begin
        state_nxt.counter_seen  = 1'b1;
        state_nxt.last_rx_count = rx_cnt;
        state_nxt.request_latch = item.frame_payload[0];
        state_nxt.timeout_left  = cfg.timeout_reload;
      end
      res_first.is_transmit   = 1'b0;
      res_first.out_id        = 11'd0;
      res_first.out_payload   = 64'd0;
      res_first.rx_status     = rx_st;
      res_first.close_request = state_nxt.request_latch;
      res_first.last          = 1'b1;
    end
  end

endmodule

>>> hw/rtl/protected_frame_link_with_timeout.sv
// ----------------------------------------------------------------------------
// protected_frame_link_with_timeout: checked control link with status frames
// Validates incoming control frames (id, length, crc, alive counter) and
// emits power and heater status frames on every tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake; in_tuser = kind (0 frame, 1 tick).
//   out_* : results; out_tuser = is_transmit, out_tlast marks the final
//           result of an item. A frame gives one verdict, a tick gives the
//           power frame followed by the heater status frame.
//   cfg_* : register port for the ids and the timeout reload; the user must
//           write it only while the block is idle, the block does not enforce it.
// Flow: an item is registered at the input, evaluated combinationally and
//   lands in the output register once the output side is free. A tick's
//   second result waits in a hold register.
// Throughput: one frame per cycle while out_tready holds; the single output
//   port moves one result per cycle, so a tick holds back the next item.
// Reset clears the link state (counter, request, timeout, tx counter), the
//   registers take their defaults and both channels come up empty.
// When the receiver stalls, results hold in place and the input register
//   fills, after which in_tready drops; nothing is lost.
// ----------------------------------------------------------------------------
module protected_frame_link_with_timeout
  import pflt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // frame_id, frame_length, frame_payload, heater_flags, hv_voltage,
  // hv_current, loss_power, max_power, zero pad
  input  logic [InTdataW-1:0]  in_tdata,
  // kind
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // out_id, out_payload, rx_status, close_request, zero pad
  output logic [OutTdataW-1:0] out_tdata,
  // is_transmit
  output logic                 out_tuser,
  output logic                 out_tlast,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CfgAddrW-1:0]  cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  pflt_cfg_t    cfg_r, cfg_nxt;
  pflt_state_t  state_r, state_nxt;
  pflt_state_t  eval_state_nxt;
  pflt_item_t   in_item_r;
  logic         in_valid_r, in_valid_nxt;
  pflt_result_t out_r, hold_r;
  logic         out_valid_r, out_valid_nxt;
  logic         hold_valid_r, hold_valid_nxt;
  pflt_result_t res_first, res_second;
  logic         two_results;
  logic         advance;
  logic         out_pop;
  logic         cfg_wr;
  logic [1:0]   cfg_idx;

  pflt_eval u_eval (
    .item        (in_item_r),
    .state       (state_r),
    .cfg         (cfg_r),
    .res_first   (res_first),
    .res_second  (res_second),
    .two_results (two_results),
    .state_nxt   (eval_state_nxt)
  );

  assign out_pop   = out_valid_r && out_tready;
  // the output side must be empty after this edge, hold included
  assign advance   = in_valid_r && (!out_valid_r || out_tready) && !hold_valid_r;
  assign in_tready = !in_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.is_transmit;
  assign out_tlast  = out_r.last;
  assign out_tdata  = {2'b00, out_r.close_request, out_r.rx_status,
                       out_r.out_payload, out_r.out_id};

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CONTROL_ID: cfg_nxt.control_frame_id = cfg_pwdata[10:0];
        REG_POWER_ID:   cfg_nxt.power_status_id  = cfg_pwdata[10:0];
        REG_HEATER_ID:  cfg_nxt.heater_status_id = cfg_pwdata[10:0];
        REG_TIMEOUT:    cfg_nxt.timeout_reload   = cfg_pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CONTROL_ID: cfg_prdata = {21'd0, cfg_r.control_frame_id};
      REG_POWER_ID:   cfg_prdata = {21'd0, cfg_r.power_status_id};
      REG_HEATER_ID:  cfg_prdata = {21'd0, cfg_r.heater_status_id};
      REG_TIMEOUT:    cfg_prdata = {24'd0, cfg_r.timeout_reload};
    endcase
  end

  // handshake control
  always_comb begin
    in_valid_nxt   = in_tready ? in_tvalid : in_valid_r;
    state_nxt      = advance ? eval_state_nxt : state_r;
    out_valid_nxt  = out_valid_r;
    hold_valid_nxt = hold_valid_r;
    if (advance) begin
      out_valid_nxt  = 1'b1;
      hold_valid_nxt = two_results;
    end else if (out_pop) begin
      out_valid_nxt  = hold_valid_r;
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_frame_id <= CONTROL_ID_RST;
      cfg_r.power_status_id  <= POWER_ID_RST;
      cfg_r.heater_status_id <= HEATER_ID_RST;
      cfg_r.timeout_reload   <= TIMEOUT_RST;
      state_r                <= '0;
      in_valid_r             <= 1'b0;
      out_valid_r            <= 1'b0;
      hold_valid_r           <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      state_r      <= state_nxt;
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.kind          <= in_tuser;
      in_item_r.frame_id      <= in_tdata[10:0];
      in_item_r.frame_length  <= in_tdata[14:11];
      in_item_r.frame_payload <= in_tdata[78:15];
      in_item_r.heater_flags  <= in_tdata[83:79];
      in_item_r.hv_voltage    <= in_tdata[99:84];
      in_item_r.hv_current    <= in_tdata[115:100];
      in_item_r.loss_power    <= in_tdata[131:116];
      in_item_r.max_power     <= in_tdata[163:132];
    end
    if (advance) begin
      out_r  <= res_first;
      hold_r <= res_second;
    end else if (out_pop && hold_valid_r) begin
      out_r <= hold_r;
    end
  end

  // a waiting second result always sits behind a shown first one
  a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("hold register valid while output register empty");

  // a shown result without last always has its follower in the hold register
  a_not_last_has_follower: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tlast) |-> hold_valid_r)
    else $error("non-final result shown without a following result");

  // a tick always leaves its heater frame in the hold register
  a_tick_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.kind == KIND_TICK) |=> (hold_valid_r && out_valid_r))
    else $error("tick item did not queue its second result");

  // the link state only moves when an item is evaluated
  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(state_r))
    else $error("link state changed without an evaluated item");

endmodule
